// ===== hdl/rtaf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the rectangle table area filter: action and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package rtaf_pkg;

    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_BELOW    = 2'd1;
    localparam logic [1:0] ACT_SMALLEST = 2'd2;
    localparam logic [1:0] ACT_LIST     = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int unsigned WORD_W = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_RB_READ,
        ST_RB_AREA,
        ST_RB_DECIDE,
        ST_SM_READ,
        ST_SM_AREA,
        ST_SM_CMP,
        ST_SM_MOVE,
        ST_LS_READ,
        ST_LS_AREA,
        ST_LS_EMIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic mark_empty;
        logic add_write;
        logic area_load;
        logic rb_decide;
        logic sm_compare;
        logic sm_move;
        logic emit_entry;
        logic emit_result;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic count_zero;
        logic last_entry;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/rtaf_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module rtaf_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_a_addr,
    output logic [WIDTH-1:0]  rd_a_data,
    input  logic [ADDR_W-1:0] rd_b_addr,
    output logic [WIDTH-1:0]  rd_b_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

// ===== hdl/rtaf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the rectangle table area filter.
// Depends on rtaf_pkg; drives datapath commands from datapath status.
module rtaf_ctrl
    import rtaf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] action,
    input  sts_t       sts,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (action)
                        ACT_ADD:      state_next = ST_ADD;
                        ACT_BELOW:    state_next = ST_RB_READ;
                        ACT_SMALLEST: state_next = sts.count_zero ? ST_RESULT : ST_SM_READ;
                        ACT_LIST:     state_next = sts.count_zero ? ST_RESULT : ST_LS_READ;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:       state_next = ST_RESULT;
            ST_RB_READ:   state_next = sts.scan_done ? ST_RESULT : ST_RB_AREA;
            ST_RB_AREA:   state_next = ST_RB_DECIDE;
            ST_RB_DECIDE: state_next = ST_RB_READ;
            ST_SM_READ:   state_next = sts.scan_done ? ST_SM_MOVE : ST_SM_AREA;
            ST_SM_AREA:   state_next = ST_SM_CMP;
            ST_SM_CMP:    state_next = ST_SM_READ;
            ST_SM_MOVE:   state_next = ST_RESULT;
            ST_LS_READ:   state_next = ST_LS_AREA;
            ST_LS_AREA:   state_next = ST_LS_EMIT;
            ST_LS_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last_entry ? ST_IDLE : ST_LS_READ;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.accept     = in_valid;
                cmd.mark_empty = in_valid && sts.count_zero
                                 && (action inside {ACT_SMALLEST, ACT_LIST});
            end
            ST_ADD:       cmd.add_write   = 1'b1;
            ST_RB_AREA:   cmd.area_load   = 1'b1;
            ST_RB_DECIDE: cmd.rb_decide   = 1'b1;
            ST_SM_AREA:   cmd.area_load   = 1'b1;
            ST_SM_CMP:    cmd.sm_compare  = 1'b1;
            ST_SM_MOVE:   cmd.sm_move     = 1'b1;
            ST_LS_AREA:   cmd.area_load   = 1'b1;
            ST_LS_EMIT:   cmd.emit_entry  = sts.out_free;
            ST_RESULT:    cmd.emit_result = sts.out_free;
            default:      cmd = '0;
        endcase
    end

endmodule

// ===== hdl/rtaf_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the rectangle table area filter: table RAM, count, scan index,
// area multiplier, best-area tracking and the output register. Depends on rtaf_pkg, rtaf_ram.
module rtaf_dp
    import rtaf_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic signed [15:0] corner_x,
    input  logic signed [15:0] corner_y,
    input  logic signed [15:0] height,
    input  logic signed [15:0] breadth,
    input  logic signed [31:0] area_limit,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic signed [15:0] left_x,
    output logic signed [15:0] bottom_y,
    output logic signed [16:0] right_x,
    output logic signed [16:0] top_y,
    output logic signed [31:0] entry_area,
    output logic               last
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [1:0]         status_reg, status_next;
    logic               out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic signed [31:0] best_area_reg, best_area_next;
    logic signed [31:0] area_reg, area_next;
    logic signed [31:0] lim_reg, lim_next;
    logic [WORD_W-1:0]  new_word_reg, new_word_next;

    logic [1:0]         out_status_reg, out_status_next;
    logic [4:0]         out_count_reg, out_count_next;
    logic signed [15:0] out_left_reg, out_left_next;
    logic signed [15:0] out_bottom_reg, out_bottom_next;
    logic signed [16:0] out_right_reg, out_right_next;
    logic signed [16:0] out_top_reg, out_top_next;
    logic signed [31:0] out_area_reg, out_area_next;
    logic               out_last_reg, out_last_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [WORD_W-1:0]  rd_a_data;
    logic [WORD_W-1:0]  rd_b_data;
    logic [CNT_W-1:0]   count_m1;

    logic signed [15:0] ent_x, ent_y, ent_h, ent_b;
    logic signed [31:0] product;
    logic               full;

    assign count_m1 = count_reg - CNT_W'(1);
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));

    rtaf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_ram (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_a_addr(idx_reg[IDX_W-1:0]),
        .rd_a_data(rd_a_data),
        .rd_b_addr(count_m1[IDX_W-1:0]),
        .rd_b_data(rd_b_data)
    );

    assign ent_x   = rd_a_data[15:0];
    assign ent_y   = rd_a_data[31:16];
    assign ent_h   = rd_a_data[47:32];
    assign ent_b   = rd_a_data[63:48];
    assign product = 32'(ent_h) * 32'(ent_b);

    always_comb
    begin
        sts.scan_done  = (idx_reg >= count_reg);
        sts.count_zero = (count_reg == '0);
        sts.last_entry = ((idx_reg + CNT_W'(1)) == count_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        best_idx_next   = best_idx_reg;
        best_area_next  = best_area_reg;
        area_next       = area_reg;
        lim_next        = lim_reg;
        new_word_next   = new_word_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_left_next   = out_left_reg;
        out_bottom_next = out_bottom_reg;
        out_right_next  = out_right_reg;
        out_top_next    = out_top_reg;
        out_area_next   = out_area_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_b_data;

        if (cmd.accept)
        begin
            new_word_next = {breadth, height, corner_y, corner_x};
            lim_next      = area_limit;
            idx_next      = '0;
            status_next   = cmd.mark_empty ? STATUS_EMPTY : STATUS_OK;
        end

        if (cmd.add_write)
        begin
            if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[IDX_W-1:0];
                wr_data    = new_word_reg;
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (cmd.area_load)
        begin
            area_next = product;
        end

        if (cmd.rb_decide)
        begin
            if (area_reg < lim_reg)
            begin
                wr_en      = 1'b1;
                count_next = count_m1;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end

        if (cmd.sm_compare)
        begin
            if (idx_reg == '0 || area_reg < best_area_reg)
            begin
                best_area_next = area_reg;
                best_idx_next  = idx_reg[IDX_W-1:0];
            end
            idx_next = idx_reg + CNT_W'(1);
        end

        if (cmd.sm_move)
        begin
            wr_en      = 1'b1;
            wr_addr    = best_idx_reg;
            count_next = count_m1;
        end

        if (cmd.emit_entry)
        begin
            out_status_next = STATUS_OK;
            out_count_next  = 5'(count_reg);
            out_left_next   = ent_x;
            out_bottom_next = ent_y;
            out_right_next  = 17'(ent_x) + 17'(ent_b);
            out_top_next    = 17'(ent_y) + 17'(ent_h);
            out_area_next   = area_reg;
            out_last_next   = sts.last_entry;
            idx_next        = idx_reg + CNT_W'(1);
        end

        if (cmd.emit_result)
        begin
            out_status_next = status_reg;
            out_count_next  = 5'(count_reg);
            out_left_next   = '0;
            out_bottom_next = '0;
            out_right_next  = '0;
            out_top_next    = '0;
            out_area_next   = '0;
            out_last_next   = 1'b1;
        end

        if (cmd.emit_entry || cmd.emit_result)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            status_reg    <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_area_reg  <= best_area_next;
        area_reg       <= area_next;
        lim_reg        <= lim_next;
        new_word_reg   <= new_word_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_left_reg   <= out_left_next;
        out_bottom_reg <= out_bottom_next;
        out_right_reg  <= out_right_next;
        out_top_reg    <= out_top_next;
        out_area_reg   <= out_area_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;
    assign left_x      = out_left_reg;
    assign bottom_y    = out_bottom_reg;
    assign right_x     = out_right_reg;
    assign top_y       = out_top_reg;
    assign entry_area  = out_area_reg;
    assign last        = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_entry || cmd.emit_result) |-> sts.out_free)
        else $error("output register overwritten while held");

    a_move_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sm_move |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove-smallest did not drop one entry");

    a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.add_write && full) |=> count_reg == $past(count_reg))
        else $error("add on full table changed count");

endmodule

// ===== hdl/rectangle_table_area_filter.sv =====
`timescale 1ns / 1ps
// Rectangle table area filter, top level. Add: writes the entry, then registers the result.
// Remove-below: reads, multiplies, removes or keeps each entry; remove-smallest: reads,
// multiplies and compares each entry in the single table RAM, then drops the smallest.
// List: reads, multiplies and emits each entry. Each result waits while the output is
// held; the next transaction is taken the cycle after the last result is registered.
// Reset (async, active low) empties the table; RAM contents are not cleared.
module rectangle_table_area_filter
    import rtaf_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [15:0] corner_x,
    input  logic signed [15:0] corner_y,
    input  logic signed [15:0] height,
    input  logic signed [15:0] breadth,
    input  logic signed [31:0] area_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [4:0]         entry_count,
    output logic signed [15:0] left_x,
    output logic signed [15:0] bottom_y,
    output logic signed [16:0] right_x,
    output logic signed [16:0] top_y,
    output logic signed [31:0] entry_area,
    output logic               last
);

    cmd_t cmd;
    sts_t sts;

    rtaf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .action  (action),
        .sts     (sts),
        .in_ready(in_ready),
        .cmd     (cmd)
    );

    rtaf_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .corner_x   (corner_x),
        .corner_y   (corner_y),
        .height     (height),
        .breadth    (breadth),
        .area_limit (area_limit),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .entry_count(entry_count),
        .left_x     (left_x),
        .bottom_y   (bottom_y),
        .right_x    (right_x),
        .top_y      (top_y),
        .entry_area (entry_area),
        .last       (last)
    );

endmodule

// ===== test/rectangle_table_area_filter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rectangle_table_area_filter: directed and random transactions,
// with a scoreboard class that predicts the table and checks every result in order.
// Depends on rtaf_pkg and the rectangle_table_area_filter RTL.
module rectangle_table_area_filter_tb
    import rtaf_pkg::*;
();

    localparam int unsigned TABLE_DEPTH  = 16;
    localparam int          RANDOM_ITEMS = 120;
    localparam int          MAX_WAIT     = 18;
    localparam int          DRAIN_CYCLES = 80;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] h;
        logic signed [15:0] b;
    } rect_t;

    typedef struct {
        logic [1:0]         status;
        logic [4:0]         count;
        logic signed [15:0] lx;
        logic signed [15:0] by;
        logic signed [16:0] rx;
        logic signed [16:0] ty;
        logic signed [31:0] area;
        logic               last;
    } reply_t;

    class rect_table_scoreboard;
        rect_t  slots[TABLE_DEPTH];
        int     used;
        reply_t expected_replies[$];
        int     errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        function logic signed [31:0] area_of(rect_t e);
            logic signed [31:0] p;
            p = 32'(e.h) * 32'(e.b);
            return p;
        endfunction

        function reply_t plain_reply(logic [1:0] st);
            reply_t r;
            r = '{default: '0};
            r.status = st;
            r.last   = 1'b1;
            return r;
        endfunction

        function void note_request(logic [1:0] act, rect_t rect, logic signed [31:0] lim);
            reply_t             r;
            int                 i;
            int                 best;
            logic signed [31:0] best_area;
            r = plain_reply(STATUS_OK);
            case (act)
                ACT_ADD:
                begin
                    if (used < TABLE_DEPTH)
                    begin
                        slots[used] = rect;
                        used++;
                    end
                    else
                        r.status = STATUS_FULL;
                end
                ACT_BELOW:
                begin
                    i = 0;
                    while (i < used)
                    begin
                        if (area_of(slots[i]) < lim)
                        begin
                            slots[i] = slots[used - 1];
                            used--;
                        end
                        else
                            i++;
                    end
                end
                ACT_SMALLEST:
                begin
                    if (used == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        best      = 0;
                        best_area = area_of(slots[0]);
                        for (i = 1; i < used; i++)
                        begin
                            if (area_of(slots[i]) < best_area)
                            begin
                                best_area = area_of(slots[i]);
                                best      = i;
                            end
                        end
                        slots[best] = slots[used - 1];
                        used--;
                    end
                end
                default:
                begin
                    if (used == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        for (i = 0; i < used; i++)
                        begin
                            r.count = 5'(used);
                            r.lx    = slots[i].x;
                            r.by    = slots[i].y;
                            r.rx    = slots[i].x + slots[i].b;
                            r.ty    = slots[i].y + slots[i].h;
                            r.area  = area_of(slots[i]);
                            r.last  = (i + 1 == used);
                            expected_replies.push_back(r);
                        end
                        return;
                    end
                end
            endcase
            r.count = 5'(used);
            expected_replies.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_reply(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                report_mismatch("result with no transaction pending");
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.count !== want.count)
                report_mismatch($sformatf("entry_count %0d, want %0d", got.count, want.count));
            if (got.lx !== want.lx)
                report_mismatch($sformatf("left_x %0d, want %0d", got.lx, want.lx));
            if (got.by !== want.by)
                report_mismatch($sformatf("bottom_y %0d, want %0d", got.by, want.by));
            if (got.rx !== want.rx)
                report_mismatch($sformatf("right_x %0d, want %0d", got.rx, want.rx));
            if (got.ty !== want.ty)
                report_mismatch($sformatf("top_y %0d, want %0d", got.ty, want.ty));
            if (got.area !== want.area)
                report_mismatch($sformatf("entry_area %0d, want %0d", got.area, want.area));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic signed [15:0] corner_x;
    logic signed [15:0] corner_y;
    logic signed [15:0] height;
    logic signed [15:0] breadth;
    logic signed [31:0] area_limit;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [15:0] left_x;
    logic signed [15:0] bottom_y;
    logic signed [16:0] right_x;
    logic signed [16:0] top_y;
    logic signed [31:0] entry_area;
    logic               last;

    rect_table_scoreboard tracker;
    int unsigned          cycles;
    bit                   send_calm;
    bit                   take_calm;

    rectangle_table_area_filter #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .corner_x   (corner_x),
        .corner_y   (corner_y),
        .height     (height),
        .breadth    (breadth),
        .area_limit (area_limit),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .entry_count(entry_count),
        .left_x     (left_x),
        .bottom_y   (bottom_y),
        .right_x    (right_x),
        .top_y      (top_y),
        .entry_area (entry_area),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("rectangle_table_area_filter_tb failed");
            $finish;
        end
    end

    function int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function logic signed [15:0] rand_dim();
        if ($urandom_range(0, 1) == 0)
            return 16'(int'($urandom_range(0, 40)) - 10);
        return 16'($urandom);
    endfunction

    task automatic send_item(input logic [1:0] act, input rect_t rect,
                             input logic signed [31:0] lim);
        int gap;
        if ($urandom_range(0, 11) == 0)
            send_calm = !send_calm;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        corner_x   <= rect.x;
        corner_y   <= rect.y;
        height     <= rect.h;
        breadth    <= rect.b;
        area_limit <= lim;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(act, rect, lim);
    endtask

    function rect_t rand_rect();
        rect_t r;
        r.x = 16'($urandom);
        r.y = 16'($urandom);
        r.h = rand_dim();
        r.b = rand_dim();
        return r;
    endfunction

    function logic signed [31:0] rand_limit();
        case ($urandom_range(0, 3))
            0: return 32'($urandom);
            1, 2:
            begin
                if (tracker.used > 0)
                    return tracker.area_of(tracker.slots[$urandom_range(0, tracker.used - 1)])
                           + int'($urandom_range(0, 2)) - 1;
                return 32'(int'($urandom_range(0, 1800)) - 200);
            end
            default: return 32'(int'($urandom_range(0, 1800)) - 200);
        endcase
    endfunction

    // result side
    initial
    begin
        reply_t got;
        int     stall;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 11) == 0)
                take_calm = !take_calm;
            stall = draw_wait(take_calm);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got.status = status;
            got.count  = entry_count;
            got.lx     = left_x;
            got.by     = bottom_y;
            got.rx     = right_x;
            got.ty     = top_y;
            got.area   = entry_area;
            got.last   = last;
            tracker.check_reply(got);
        end
    end

    initial
    begin
        logic [1:0] act;
        int         k;
        tracker    = new();
        send_calm  = 1'b0;
        take_calm  = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        action     <= ACT_ADD;
        corner_x   <= '0;
        corner_y   <= '0;
        height     <= '0;
        breadth    <= '0;
        area_limit <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table cases
        send_item(ACT_LIST, rand_rect(), rand_limit());
        send_item(ACT_SMALLEST, rand_rect(), rand_limit());
        send_item(ACT_BELOW, rand_rect(), 32'sh7fffffff);

        // field extremes
        send_item(ACT_ADD, '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, '0);
        send_item(ACT_ADD, '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, '0);
        send_item(ACT_ADD, '{16'sh0000, 16'sh0000, 16'sh8000, 16'sh7fff}, '0);
        send_item(ACT_ADD, '{-16'sd1, 16'sd1, 16'sd0, 16'sd5}, '0);
        send_item(ACT_LIST, rand_rect(), rand_limit());
        send_item(ACT_SMALLEST, rand_rect(), rand_limit());
        send_item(ACT_BELOW, rand_rect(), 32'sh80000000);

        // fill, overflow, then clear everything
        while (tracker.used < TABLE_DEPTH)
            send_item(ACT_ADD, rand_rect(), rand_limit());
        send_item(ACT_ADD, rand_rect(), rand_limit());
        send_item(ACT_LIST, rand_rect(), rand_limit());
        send_item(ACT_BELOW, rand_rect(), 32'sh7fffffff);
        send_item(ACT_LIST, rand_rect(), rand_limit());

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if ($urandom_range(0, 99) < (tracker.used < 4 ? 70 : 45))
                act = ACT_ADD;
            else
            begin
                case ($urandom_range(0, 2))
                    0: act = ACT_BELOW;
                    1: act = ACT_SMALLEST;
                    default: act = ACT_LIST;
                endcase
            end
            send_item(act, rand_rect(), rand_limit());
        end

        in_valid <= 1'b0;
        while (tracker.expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.expected_replies.size() != 0)
            tracker.report_mismatch("results still pending at end of run");

        if (tracker.errors == 0)
            $display("rectangle_table_area_filter_tb passed");
        else
            $display("rectangle_table_area_filter_tb failed");
        $finish;
    end

endmodule
